// ----- src/tri_pkg.sv -----
`timescale 1ns / 1ps
package tri_pkg;

    // frame geometry
    localparam int WIDTH  = 256;
    localparam int HEIGHT = 256;
    localparam int DEPTH  = WIDTH * HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    // operation codes
    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_DRAW  = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // input beat
    typedef struct packed {
        t_op                op;
        logic [7:0]         ax;
        logic [7:0]         ay;
        logic signed [15:0] af;
        logic [7:0]         bx;
        logic [7:0]         by_row;
        logic signed [15:0] bf;
        logic [7:0]         cx;
        logic [7:0]         cy;
        logic signed [15:0] cf;
        logic [7:0]         read_x;
        logic [7:0]         read_y;
    } t_item;

    // result beat
    typedef struct packed {
        logic signed [8:0] pixel_value;
        logic [16:0]       pixels_drawn;
        logic              degenerate;
    } t_result;

    // controller states
    typedef enum logic [4:0] {
        ST_INIT, ST_IDLE, ST_CLEAR, ST_DET, ST_EA, ST_EB, ST_EC, ST_TEST,
        ST_MUL0, ST_MUL1, ST_MUL2, ST_MUL3, ST_CLASS, ST_DIV, ST_WRITE,
        ST_NEXT, ST_RD, ST_RDW, ST_DONE
    } t_state;

    // shared edge unit operand select
    typedef enum logic [1:0] {
        SEL_DET, SEL_EA, SEL_EB, SEL_EC
    } t_edge_sel;

    // multiplier operand select
    typedef enum logic [1:0] {
        MUL_A, MUL_B, MUL_C, MUL_OFF
    } t_mul_sel;

    typedef enum logic [1:0] {
        ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_OFF
    } t_acc_op;

    // controller to datapath
    typedef struct packed {
        logic      load;
        logic      clr_wr;
        logic      det;
        logic      edge_en;
        t_edge_sel edge_sel;
        t_mul_sel  mul_sel;
        t_acc_op   acc_op;
        logic      classify;
        logic      div_en;
        logic [2:0] div_bit;
        logic      wr_px;
        logic      step;
        logic      rd;
        logic      rd_latch;
        logic      emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic degen;
        logic in_tri;
        logic need_div;
        logic last_px;
        logic clr_last;
    } t_status;

endpackage

// ----- src/tri_ctrl.sv -----
`timescale 1ns / 1ps
module tri_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  tri_pkg::t_op    i_op,
    input  tri_pkg::t_status i_st,
    output tri_pkg::t_cmd   o_cmd,
    output logic            busy
);
    import tri_pkg::*;

    t_state     r_state, n_state;
    logic [2:0] r_cnt, n_cnt;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_cnt   <= 3'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_INIT:  if (i_st.clr_last) n_state = ST_IDLE;
            ST_IDLE: begin
                if (start) begin
                    case (i_op)
                        OP_CLEAR: n_state = ST_CLEAR;
                        OP_DRAW:  n_state = ST_DET;
                        OP_READ:  n_state = ST_RD;
                        default:  n_state = ST_DONE;
                    endcase
                end
            end
            ST_CLEAR: if (i_st.clr_last) n_state = ST_DONE;
            ST_DET:   n_state = ST_EA;
            ST_EA:    n_state = i_st.degen ? ST_DONE : ST_EB;
            ST_EB:    n_state = ST_EC;
            ST_EC:    n_state = ST_TEST;
            ST_TEST:  n_state = i_st.in_tri ? ST_MUL0 : ST_NEXT;
            ST_MUL0:  n_state = ST_MUL1;
            ST_MUL1:  n_state = ST_MUL2;
            ST_MUL2:  n_state = ST_MUL3;
            ST_MUL3:  n_state = ST_CLASS;
            ST_CLASS: begin
                n_cnt   = 3'd7;
                n_state = i_st.need_div ? ST_DIV : ST_WRITE;
            end
            ST_DIV: begin
                n_cnt = r_cnt - 3'd1;
                if (r_cnt == 3'd0) n_state = ST_WRITE;
            end
            ST_WRITE: n_state = ST_NEXT;
            ST_NEXT:  n_state = i_st.last_px ? ST_DONE : ST_TEST;
            ST_RD:    n_state = ST_RDW;
            ST_RDW:   n_state = ST_DONE;
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd          = '0;
        o_cmd.edge_sel = SEL_DET;
        o_cmd.mul_sel  = MUL_OFF;
        o_cmd.acc_op   = ACC_HOLD;
        o_cmd.div_bit  = r_cnt;
        busy           = 1'b1;
        case (r_state)
            ST_INIT:  o_cmd.clr_wr = 1'b1;
            ST_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            ST_CLEAR: o_cmd.clr_wr = 1'b1;
            ST_DET:   o_cmd.det = 1'b1;
            ST_EA: begin
                o_cmd.edge_en  = 1'b1;
                o_cmd.edge_sel = SEL_EA;
            end
            ST_EB: begin
                o_cmd.edge_en  = 1'b1;
                o_cmd.edge_sel = SEL_EB;
            end
            ST_EC: begin
                o_cmd.edge_en  = 1'b1;
                o_cmd.edge_sel = SEL_EC;
            end
            ST_MUL0:  o_cmd.mul_sel = MUL_A;
            ST_MUL1: begin
                o_cmd.mul_sel = MUL_B;
                o_cmd.acc_op  = ACC_LOAD;
            end
            ST_MUL2: begin
                o_cmd.mul_sel = MUL_C;
                o_cmd.acc_op  = ACC_ADD;
            end
            ST_MUL3:  o_cmd.acc_op = ACC_ADD;
            ST_CLASS: o_cmd.classify = 1'b1;
            ST_DIV:   o_cmd.div_en = 1'b1;
            ST_WRITE: o_cmd.wr_px = 1'b1;
            ST_NEXT:  o_cmd.step = !i_st.last_px;
            ST_RD:    o_cmd.rd = 1'b1;
            ST_RDW:   o_cmd.rd_latch = 1'b1;
            ST_DONE:  o_cmd.emit = 1'b1;
            default:  o_cmd.emit = 1'b0;
        endcase
    end

endmodule

// ----- src/tri_datapath.sv -----
`timescale 1ns / 1ps
module tri_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tri_pkg::t_item   i_item,
    input  tri_pkg::t_cmd    i_cmd,
    output tri_pkg::t_status o_st,
    output tri_pkg::t_result o_result,
    output logic             o_valid
);
    import tri_pkg::*;

    function automatic logic signed [8:0] diff9(input logic [7:0] a, input logic [7:0] b);
        diff9 = $signed({1'b0, a}) - $signed({1'b0, b});
    endfunction

    function automatic logic [7:0] min3(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
        logic [7:0] m;
        m    = (a < b) ? a : b;
        min3 = (m < c) ? m : c;
    endfunction

    function automatic logic [7:0] max3(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
        logic [7:0] m;
        m    = (a > b) ? a : b;
        max3 = (m > c) ? m : c;
    endfunction

    logic [8:0] mem [DEPTH];

    t_item              r_item;
    logic [ADDR_W-1:0]  r_clr;
    logic               r_degen, r_neg;
    logic [17:0]        r_d;
    logic signed [39:0] r_lim;
    logic [7:0]         r_x0, r_x1, r_y0, r_y1, r_px, r_py;
    logic signed [19:0] r_dxa, r_dxb, r_dxc, r_dya, r_dyb, r_dyc;
    logic signed [19:0] r_ea, r_eb, r_ec, r_ra, r_rb, r_rc;
    logic signed [35:0] r_prod;
    logic signed [39:0] r_s, r_rem;
    logic [7:0]         r_val;
    logic [16:0]        r_drawn;
    logic [8:0]         r_rdata;
    logic signed [8:0]  r_pv;
    t_result            r_out;
    logic               r_out_valid;

    // shared edge unit: a1*b1 + a2*b2
    logic signed [8:0]  u_a1, u_b1, u_a2, u_b2;
    logic signed [17:0] u_p1, u_p2;
    logic signed [19:0] u_sum, u_adj;

    always_comb begin
        case (i_cmd.edge_sel)
            SEL_DET: begin
                u_a1 = diff9(r_item.ax, r_item.bx); u_b1 = diff9(r_item.by_row, r_item.cy);
                u_a2 = diff9(r_item.cx, r_item.bx); u_b2 = diff9(r_item.ay, r_item.by_row);
            end
            SEL_EA: begin
                u_a1 = diff9(r_x0, r_item.bx);      u_b1 = diff9(r_item.by_row, r_item.cy);
                u_a2 = diff9(r_item.cx, r_item.bx); u_b2 = diff9(r_y0, r_item.by_row);
            end
            SEL_EB: begin
                u_a1 = diff9(r_x0, r_item.cx);      u_b1 = diff9(r_item.cy, r_item.ay);
                u_a2 = diff9(r_item.ax, r_item.cx); u_b2 = diff9(r_y0, r_item.cy);
            end
            default: begin
                u_a1 = diff9(r_x0, r_item.ax);      u_b1 = diff9(r_item.ay, r_item.by_row);
                u_a2 = diff9(r_item.bx, r_item.ax); u_b2 = diff9(r_y0, r_item.ay);
            end
        endcase
        u_p1  = u_a1 * u_b1;
        u_p2  = u_a2 * u_b2;
        u_sum = 20'(u_p1) + 20'(u_p2);
        u_adj = r_neg ? -u_sum : u_sum;
    end

    // per-pixel interpolation multiplier
    logic signed [19:0] m_e;
    logic signed [15:0] m_f;
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_A:   begin m_e = r_ea; m_f = r_item.af; end
            MUL_B:   begin m_e = r_eb; m_f = r_item.bf; end
            MUL_C:   begin m_e = r_ec; m_f = r_item.cf; end
            default: begin m_e = r_ec; m_f = r_item.cf; end
        endcase
    end

    // status and helpers
    logic signed [39:0] d_ext, trial;
    logic               in_frame, rd_in_frame, s_neg, s_over;
    logic [ADDR_W-1:0]  px_addr, rd_addr;

    always_comb begin
        d_ext       = $signed({22'd0, r_d});
        trial       = r_rem - ((d_ext <<< 4) <<< i_cmd.div_bit);
        in_frame    = (32'(r_px) < 32'(WIDTH)) && (32'(r_py) < 32'(HEIGHT));
        rd_in_frame = (32'(r_item.read_x) < 32'(WIDTH)) && (32'(r_item.read_y) < 32'(HEIGHT));
        px_addr     = ADDR_W'(r_py) * ADDR_W'(WIDTH) + ADDR_W'(r_px);
        rd_addr     = ADDR_W'(r_item.read_y) * ADDR_W'(WIDTH) + ADDR_W'(r_item.read_x);
        s_neg       = r_s < 0;
        s_over      = r_s > r_lim;
        o_st.degen    = r_degen;
        o_st.in_tri   = in_frame && (r_ea >= 0) && (r_eb >= 0) && (r_ec >= 0);
        o_st.need_div = !s_neg && !s_over;
        o_st.last_px  = (r_px == r_x1) && (r_py == r_y1);
        o_st.clr_last = r_clr == ADDR_W'(DEPTH - 1);
    end

    // frame store write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            mem[r_clr] <= 9'h1FF;
        end else if (i_cmd.wr_px) begin
            mem[px_addr] <= {1'b0, r_val};
        end
    end

    // frame store read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // clear sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.load) begin
            r_clr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr <= r_clr + ADDR_W'(1);
        end
    end

    // triangle setup and scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item  <= i_item;
            r_drawn <= '0;
            r_degen <= 1'b0;
            r_pv    <= '0;
        end
        if (i_cmd.det) begin
            r_degen <= (u_sum == 0);
            r_neg   <= (u_sum < 0);
            r_d     <= 18'((u_sum < 0) ? -u_sum : u_sum);
            r_x0    <= min3(r_item.ax, r_item.bx, r_item.cx);
            r_x1    <= max3(r_item.ax, r_item.bx, r_item.cx);
            r_y0    <= min3(r_item.ay, r_item.by_row, r_item.cy);
            r_y1    <= max3(r_item.ay, r_item.by_row, r_item.cy);
            r_px    <= min3(r_item.ax, r_item.bx, r_item.cx);
            r_py    <= min3(r_item.ay, r_item.by_row, r_item.cy);
            r_dxa   <= (u_sum < 0) ? -20'(diff9(r_item.by_row, r_item.cy))
                                   :  20'(diff9(r_item.by_row, r_item.cy));
            r_dxb   <= (u_sum < 0) ? -20'(diff9(r_item.cy, r_item.ay))
                                   :  20'(diff9(r_item.cy, r_item.ay));
            r_dxc   <= (u_sum < 0) ? -20'(diff9(r_item.ay, r_item.by_row))
                                   :  20'(diff9(r_item.ay, r_item.by_row));
            r_dya   <= (u_sum < 0) ? -20'(diff9(r_item.cx, r_item.bx))
                                   :  20'(diff9(r_item.cx, r_item.bx));
            r_dyb   <= (u_sum < 0) ? -20'(diff9(r_item.ax, r_item.cx))
                                   :  20'(diff9(r_item.ax, r_item.cx));
            r_dyc   <= (u_sum < 0) ? -20'(diff9(r_item.bx, r_item.ax))
                                   :  20'(diff9(r_item.bx, r_item.ax));
        end
        // initial edge values at the box corner; limit 4080*d
        if (i_cmd.edge_en) begin
            case (i_cmd.edge_sel)
                SEL_EA: begin
                    r_ea  <= u_adj;
                    r_ra  <= u_adj;
                    r_lim <= (d_ext <<< 12) - (d_ext <<< 4);
                end
                SEL_EB: begin
                    r_eb <= u_adj;
                    r_rb <= u_adj;
                end
                default: begin
                    r_ec <= u_adj;
                    r_rc <= u_adj;
                end
            endcase
        end
        // walk the bounding box
        if (i_cmd.step) begin
            if (r_px == r_x1) begin
                r_px <= r_x0;
                r_py <= r_py + 8'd1;
                r_ra <= r_ra + r_dya;
                r_rb <= r_rb + r_dyb;
                r_rc <= r_rc + r_dyc;
                r_ea <= r_ra + r_dya;
                r_eb <= r_rb + r_dyb;
                r_ec <= r_rc + r_dyc;
            end else begin
                r_px <= r_px + 8'd1;
                r_ea <= r_ea + r_dxa;
                r_eb <= r_eb + r_dxb;
                r_ec <= r_ec + r_dxc;
            end
        end
        // weighted sum
        r_prod <= m_e * m_f;
        case (i_cmd.acc_op)
            ACC_LOAD: r_s <= 40'(r_prod);
            ACC_ADD:  r_s <= r_s + 40'(r_prod);
            default:  r_s <= r_s;
        endcase
        // clamp or set up the divide
        if (i_cmd.classify) begin
            r_val <= s_neg ? 8'd0 : (s_over ? 8'd255 : 8'd0);
            r_rem <= r_s + (d_ext <<< 3);
        end
        // restoring divide by 16*d, one quotient bit a cycle
        if (i_cmd.div_en && (trial >= 0)) begin
            r_rem                <= trial;
            r_val[i_cmd.div_bit] <= 1'b1;
        end
        if (i_cmd.wr_px) begin
            r_drawn <= r_drawn + 17'd1;
        end
        if (i_cmd.rd_latch) begin
            r_pv <= rd_in_frame ? $signed(r_rdata) : -9'sd1;
        end
        if (i_cmd.emit) begin
            r_out.pixel_value  <= r_pv;
            r_out.pixels_drawn <= r_drawn;
            r_out.degenerate   <= r_degen;
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.emit;
        end
    end

    assign o_result = r_out;
    assign o_valid  = r_out_valid;

endmodule

// ----- src/triangle_raster_interpolator.sv -----
`timescale 1ns / 1ps
// Triangle rasterizer into a 256x256 store of 9-bit pixels (-1 = unwritten).
// Issue a beat with start while busy is low; one result follows per beat, shown
// for one cycle with o_valid and it cannot be held off, so take it when it comes.
// After reset the block sweeps the store to -1 (busy high); a clear op runs
// the same sweep, and a read returns one stored pixel. A draw first finds the
// signed area and the edge values at the bounding-box corner, then walks the
// box: pixels outside the triangle are skipped, the rest go through the shared
// multiplier and are clamped or divided by the serial divider, one quotient bit
// per cycle; a zero-area triangle returns straight after setup.
module triangle_raster_interpolator (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  tri_pkg::t_item   i_item,
    output logic             busy,
    output tri_pkg::t_result o_result,
    output logic             o_valid
);
    import tri_pkg::*;

    t_cmd    cmd;
    t_status st;

    // sequencer
    tri_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_op    (i_item.op),
        .i_st    (st),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    // arithmetic and frame store
    tri_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_st     (st),
        .o_result (o_result),
        .o_valid  (o_valid)
    );

endmodule

// ----- src/tri_checker.sv -----
`timescale 1ns / 1ps
module tri_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input tri_pkg::t_result o_result,
    input logic             o_valid
);
    import tri_pkg::*;

    // an accepted beat always keeps the block busy next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accept did not raise busy");

    // a result shows while the block is already free
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result while busy");

    // one cycle strobe
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("strobe longer than one cycle");

    // degenerate triangle draws nothing
    a_degen_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.degenerate) |-> (o_result.pixels_drawn == 17'd0))
        else $error("degenerate draw counted pixels");

    // a read result carries no draw count
    a_read_nodraw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.pixel_value != 9'sd0)) |->
        ((o_result.pixels_drawn == 17'd0) && !o_result.degenerate))
        else $error("read result mixed with draw fields");

endmodule

bind triangle_raster_interpolator tri_checker u_tri_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_result (o_result),
    .o_valid  (o_valid)
);
